@@ hdl/fst_pkg.sv @@
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, codes and packing constants for the feed sequence tracker.
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int FST_ENTRY_SLOTS_DEF = 1024;

   localparam int SLOT_W   = 10;
   localparam int PROD_W   = 16;
   localparam int WORD_W   = 64;
   localparam int STATUS_W = 5;
   localparam int MAXE_W   = 11;

   localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 11'd1024;

   // request tdata layout, lowest bit first
   localparam int REQ_SLOT_LO  = 0;
   localparam int REQ_PROD_LO  = REQ_SLOT_LO + SLOT_W;
   localparam int REQ_OK_BIT   = REQ_PROD_LO + PROD_W;
   localparam int REQ_EPOCH_LO = REQ_OK_BIT + 1;
   localparam int REQ_SEQ_LO   = REQ_EPOCH_LO + WORD_W;
   localparam int REQ_TIME_LO  = REQ_SEQ_LO + WORD_W;
   localparam int REQ_CAP_LO   = REQ_TIME_LO + WORD_W;
   localparam int REQ_FRESH_LO = REQ_CAP_LO + WORD_W;
   localparam int REQ_BID_LO   = REQ_FRESH_LO + WORD_W;
   localparam int REQ_ASK_LO   = REQ_BID_LO + WORD_W;
   localparam int REQ_DIG_LO   = REQ_ASK_LO + WORD_W;
   localparam int REQ_USED_W   = REQ_DIG_LO + WORD_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int RSP_STATUS_LO = 0;
   localparam int RSP_ACC_BIT   = RSP_STATUS_LO + STATUS_W;
   localparam int RSP_DUP_BIT   = RSP_ACC_BIT + 1;
   localparam int RSP_GAP_BIT   = RSP_DUP_BIT + 1;
   localparam int RSP_GEN_LO    = RSP_GAP_BIT + 1;
   localparam int RSP_DIG_LO    = RSP_GEN_LO + WORD_W;
   localparam int RSP_USED_W    = RSP_DIG_LO + WORD_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic CMD_APPLY = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [STATUS_W-1:0] rsp_status_type;

   localparam rsp_status_type RS_ACCEPTED      = 5'd0;
   localparam rsp_status_type RS_GAP_RECORDED  = 5'd1;
   localparam rsp_status_type RS_DUPLICATE     = 5'd2;
   localparam rsp_status_type RS_FIELDS_BAD    = 5'd3;
   localparam rsp_status_type RS_ORDERING_BAD  = 5'd4;
   localparam rsp_status_type RS_TIME_BAD      = 5'd5;
   localparam rsp_status_type RS_QUOTE_BAD     = 5'd6;
   localparam rsp_status_type RS_CAPACITY      = 5'd7;
   localparam rsp_status_type RS_EPOCH_STALE   = 5'd8;
   localparam rsp_status_type RS_WRITER_CONFL  = 5'd9;
   localparam rsp_status_type RS_SEQ_STALE     = 5'd10;
   localparam rsp_status_type RS_SEQ_CONFL     = 5'd11;
   localparam rsp_status_type RS_EPOCH_START   = 5'd12;
   localparam rsp_status_type RS_GEN_EXHAUSTED = 5'd13;
   localparam rsp_status_type RS_READY         = 5'd14;
   localparam rsp_status_type RS_MISSING       = 5'd15;
   localparam rsp_status_type RS_GAP           = 5'd16;
   localparam rsp_status_type RS_CLOCK_REGR    = 5'd17;
   localparam rsp_status_type RS_STALE         = 5'd18;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL
   } fsm_state_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic              present;
      logic [WORD_W-1:0] epoch;
      logic [WORD_W-1:0] seq;
      logic [PROD_W-1:0] producer;
      logic [WORD_W-1:0] generation;
      logic              gap;
      logic [WORD_W-1:0] digest;
      logic [WORD_W-1:0] captured;
      logic [WORD_W-1:0] fresh;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // request as held while its entry is read back
   typedef struct packed {
      logic              command;
      logic              slot_ok;
      rsp_status_type    pre_code;
      logic [PROD_W-1:0] producer;
      logic [WORD_W-1:0] epoch;
      logic [WORD_W-1:0] seq;
      logic [WORD_W-1:0] seq_m1;
      logic              seq_one;
      logic [WORD_W-1:0] time_ms;
      logic [WORD_W-1:0] captured;
      logic [WORD_W-1:0] fresh;
      logic [WORD_W-1:0] digest;
   } item_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic clear_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_full;
   } dp_status_type;

endpackage

@@ hdl/fst_ram.sv @@
// ----------------------------------------------------------------------------
// fst_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fst_ctrl.sv @@
// ----------------------------------------------------------------------------
// fst_ctrl
// Sequencer: clearing pass after reset, then capture / evaluate per request.
// ----------------------------------------------------------------------------
module fst_ctrl
   import fst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output ctl_cmd_type   cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            // hold the read data until the output register is free
            if (!sts.rsp_full) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

@@ hdl/fst_datapath.sv @@
// ----------------------------------------------------------------------------
// fst_datapath
// Request checks, entry memory, ordering rules, occupancy and result register.
// ----------------------------------------------------------------------------
module fst_datapath
   import fst_pkg::*;
#(
   parameter int ENTRY_SLOTS = FST_ENTRY_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output dp_status_type         sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [MAXE_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(ENTRY_SLOTS);

   // request field decode
   logic [SLOT_W-1:0]        req_slot;
   logic [16:0]              slot_wide;
   logic [WORD_W-1:0]        req_epoch;
   logic [WORD_W-1:0]        req_seq;
   logic [WORD_W-1:0]        req_time;
   logic [WORD_W-1:0]        req_cap;
   logic [WORD_W-1:0]        req_fresh;
   logic signed [WORD_W-1:0] req_bid;
   logic signed [WORD_W-1:0] req_ask;
   logic                     req_slot_ok;
   rsp_status_type           pre_code;

   item_type          item_ff;
   item_type          item_in;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     addr_in;
   logic [AW-1:0]     clr_cnt_ff;
   logic [AW-1:0]     clr_cnt_in;
   logic [MAXE_W-1:0] max_entries_ff;
   logic [MAXE_W-1:0] max_entries_in;
   logic [MAXE_W-1:0] occ_ff;
   logic [MAXE_W-1:0] occ_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [ENTRY_W-1:0] rd_word;
   entry_type          ent;
   entry_type          new_entry;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;

   rsp_status_type    res_status;
   logic              res_acc;
   logic              res_dup;
   logic              res_gap;
   logic [WORD_W-1:0] res_gen;
   logic [WORD_W-1:0] res_dig;
   logic              do_store;
   logic              advance;
   logic              occ_inc;
   logic              new_gap;
   logic [WORD_W-1:0] new_gen;

   assign req_slot  = req_tdata[REQ_SLOT_LO +: SLOT_W];
   assign slot_wide = 17'(req_slot);
   assign req_epoch = req_tdata[REQ_EPOCH_LO +: WORD_W];
   assign req_seq   = req_tdata[REQ_SEQ_LO +: WORD_W];
   assign req_time  = req_tdata[REQ_TIME_LO +: WORD_W];
   assign req_cap   = req_tdata[REQ_CAP_LO +: WORD_W];
   assign req_fresh = req_tdata[REQ_FRESH_LO +: WORD_W];
   assign req_bid   = $signed(req_tdata[REQ_BID_LO +: WORD_W]);
   assign req_ask   = $signed(req_tdata[REQ_ASK_LO +: WORD_W]);
   assign req_slot_ok = slot_wide < 17'(ENTRY_SLOTS);

   // checks that need only the request, in priority order
   always_comb begin
      if (!req_tdata[REQ_OK_BIT]) begin
         pre_code = RS_FIELDS_BAD;
      end else if (req_epoch == '0 || req_seq == '0) begin
         pre_code = RS_ORDERING_BAD;
      end else if (req_time == '0 || req_cap < req_time || req_fresh < req_cap) begin
         pre_code = RS_TIME_BAD;
      end else if (req_ask < req_bid) begin
         pre_code = RS_QUOTE_BAD;
      end else if (!req_slot_ok) begin
         pre_code = RS_CAPACITY;
      end else begin
         pre_code = RS_ACCEPTED;
      end
   end

   always_comb begin
      item_in          = item_ff;
      addr_in          = addr_ff;
      if (cmd.capture) begin
         item_in.command  = req_tuser;
         item_in.slot_ok  = req_slot_ok;
         item_in.pre_code = pre_code;
         item_in.producer = req_tdata[REQ_PROD_LO +: PROD_W];
         item_in.epoch    = req_epoch;
         item_in.seq      = req_seq;
         item_in.seq_m1   = req_seq - 64'd1;
         item_in.seq_one  = req_seq == 64'd1;
         item_in.time_ms  = req_time;
         item_in.captured = req_cap;
         item_in.fresh    = req_fresh;
         item_in.digest   = req_tdata[REQ_DIG_LO +: WORD_W];
         addr_in          = slot_wide[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      addr_ff <= addr_in;
   end

   fst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (slot_wide[AW-1:0]),
      .rd_data (rd_word)
   );

   assign ent = entry_type'(rd_word);

   // ordering rules against the entry read back
   always_comb begin
      res_status = RS_MISSING;
      res_acc    = 1'b0;
      res_dup    = 1'b0;
      res_gap    = 1'b0;
      res_gen    = '0;
      res_dig    = '0;
      do_store   = 1'b0;
      advance    = 1'b0;
      occ_inc    = 1'b0;
      new_gap    = 1'b0;
      new_gen    = '0;
      if (item_ff.command == CMD_QUERY) begin
         if (item_ff.slot_ok && ent.present) begin
            res_gap = ent.gap;
            res_gen = ent.generation;
            res_dig = ent.digest;
            if (ent.gap) begin
               res_status = RS_GAP;
            end else if (item_ff.time_ms < ent.captured) begin
               res_status = RS_CLOCK_REGR;
            end else if (item_ff.time_ms > ent.fresh) begin
               res_status = RS_STALE;
            end else begin
               res_status = RS_READY;
            end
         end
      end else if (item_ff.pre_code != RS_ACCEPTED) begin
         res_status = item_ff.pre_code;
      end else if (!ent.present) begin
         if (occ_ff >= max_entries_ff) begin
            res_status = RS_CAPACITY;
         end else begin
            occ_inc  = 1'b1;
            do_store = 1'b1;
            new_gap  = !item_ff.seq_one;
            new_gen  = 64'd1;
         end
      end else if (item_ff.epoch < ent.epoch) begin
         res_status = RS_EPOCH_STALE;
      end else if (item_ff.epoch == ent.epoch) begin
         if (item_ff.producer != ent.producer) begin
            res_status = RS_WRITER_CONFL;
         end else if (item_ff.seq < ent.seq) begin
            res_status = RS_SEQ_STALE;
         end else if (item_ff.seq == ent.seq) begin
            res_acc    = item_ff.digest == ent.digest;
            res_dup    = res_acc;
            res_status = res_acc ? RS_DUPLICATE : RS_SEQ_CONFL;
            res_gap    = ent.gap;
            res_gen    = ent.generation;
            res_dig    = ent.digest;
         end else begin
            // seq is nonzero here, so seq - 1 == stored matches stored + 1 == seq
            new_gap = ent.gap || (item_ff.seq_m1 != ent.seq);
            advance = 1'b1;
         end
      end else if (!item_ff.seq_one) begin
         res_status = RS_EPOCH_START;
      end else begin
         advance = 1'b1;
      end
      if (advance) begin
         if (&ent.generation) begin
            res_status = RS_GEN_EXHAUSTED;
         end else begin
            do_store = 1'b1;
            new_gen  = ent.generation + 64'd1;
         end
      end
      if (do_store) begin
         res_status = new_gap ? RS_GAP_RECORDED : RS_ACCEPTED;
         res_acc    = 1'b1;
         res_gap    = new_gap;
         res_gen    = new_gen;
         res_dig    = item_ff.digest;
      end
   end

   always_comb begin
      new_entry            = '0;
      new_entry.present    = 1'b1;
      new_entry.epoch      = item_ff.epoch;
      new_entry.seq        = item_ff.seq;
      new_entry.producer   = item_ff.producer;
      new_entry.generation = new_gen;
      new_entry.gap        = new_gap;
      new_entry.digest     = item_ff.digest;
      new_entry.captured   = item_ff.captured;
      new_entry.fresh      = item_ff.fresh;
   end

   assign ram_we    = cmd.clear_step || (cmd.commit && do_store);
   assign ram_waddr = cmd.clear_step ? clr_cnt_ff : addr_ff;
   assign ram_wdata = cmd.clear_step ? '0 : ENTRY_W'(new_entry);

   assign clr_cnt_in     = cmd.clear_step ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
   assign max_entries_in = csr_wr_en ? csr_wr_data : max_entries_ff;
   assign occ_in         = (cmd.commit && occ_inc) ? occ_ff + MAXE_W'(1) : occ_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[RSP_STATUS_LO +: STATUS_W] = res_status;
         rsp_data_in[RSP_ACC_BIT]               = res_acc;
         rsp_data_in[RSP_DUP_BIT]               = res_dup;
         rsp_data_in[RSP_GAP_BIT]               = res_gap;
         rsp_data_in[RSP_GEN_LO +: WORD_W]      = res_gen;
         rsp_data_in[RSP_DIG_LO +: WORD_W]      = res_dig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff     <= '0;
         max_entries_ff <= MAX_ENTRIES_RST;
         occ_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clr_cnt_ff     <= clr_cnt_in;
         max_entries_ff <= max_entries_in;
         occ_ff         <= occ_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.clear_last = clr_cnt_ff == AW'(ENTRY_SLOTS - 1);
   assign sts.rsp_full   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;

   a_no_commit_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten while stalled");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("evaluated request produced no response");

   a_occ_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != $past(occ_ff)) |-> (occ_ff == $past(occ_ff) + MAXE_W'(1)))
      else $error("occupied count moved by other than one");

   a_accept_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[RSP_STATUS_LO +: STATUS_W] == RS_ACCEPTED ||
       rsp_data_ff[RSP_STATUS_LO +: STATUS_W] == RS_GAP_RECORDED))
      |-> rsp_data_ff[RSP_ACC_BIT])
      else $error("stored apply reported without accepted flag");

endmodule

@@ hdl/feed_sequence_tracker_top.sv @@
// ----------------------------------------------------------------------------
// feed_sequence_tracker_top
// Per-instrument quote ordering table with readiness queries.
// ----------------------------------------------------------------------------
// Requests enter on req_* (tuser: 0 apply a quote event, 1 readiness query);
// every request yields exactly one response on rsp_*. csr_wr_en/csr_wr_data
// set the entry capacity (max_entries, reset 1024).
// The request and its entry are registered on acceptance, the response once
// evaluated; the next request waits for this single read-modify-write
// of the entry memory (registered read, then evaluate and write back).
// A request to the same slot as the previous one sees its update directly.
// Reset: a clearing pass writes every entry as absent, one per cycle;
// req_tready stays low during it. csr writes are taken.
// Stall: a response waits in the output register; one more request is
// accepted and evaluated meanwhile, and it waits until the output frees up.
// ----------------------------------------------------------------------------
module feed_sequence_tracker_top
   import fst_pkg::*;
#(
   parameter int ENTRY_SLOTS = FST_ENTRY_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slot, producer_id, fields_ok, epoch, seq_no, time_ms, captured_ms,
   // fresh_until, bid_price, ask_price, content_digest, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, accepted, duplicate, gap_flag, generation, entry_digest
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [MAXE_W-1:0]     csr_wr_data
);

   ctl_cmd_type   cmd;
   dp_status_type sts;

   fst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fst_datapath #(
      .ENTRY_SLOTS (ENTRY_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule
